// ===== src/mexp_pkg.sv =====
// Package for the modular exponentiation block.
// Holds the sequencer state type and the register index codes. No dependencies.
`default_nettype none

package mexp_pkg;

   // Sequencer states of the square-and-multiply controller.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT,
      ST_HOLD
   } mexp_state_type;

   // Register index codes of the configuration port.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 2'd1;

endpackage

`default_nettype wire

// ===== src/mexp_modmul.sv =====
// Bit-serial modular multiplier: product = (a * b) mod m, one bit of b per cycle.
// Stand-alone module, no package dependency; instantiated by modular_exponentiation.
`default_nettype none

module mexp_modmul #(
   parameter int unsigned WORD_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [WORD_WIDTH-1:0] operand_a,
   input  wire logic [WORD_WIDTH-1:0] operand_b,
   input  wire logic [WORD_WIDTH-1:0] modulus,
   output logic                       busy,
   output logic                       done,
   output logic [WORD_WIDTH-1:0]      product
);

   localparam int unsigned CNT_WIDTH = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(WORD_WIDTH - 1);

   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [WORD_WIDTH-1:0] a_ff;
   logic [WORD_WIDTH-1:0] b_ff;
   logic [WORD_WIDTH-1:0] m_ff;
   logic [CNT_WIDTH-1:0]  cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [WORD_WIDTH+1:0] sum;
   logic [WORD_WIDTH+1:0] m_one;
   logic [WORD_WIDTH+1:0] m_two;
   logic [WORD_WIDTH+1:0] sub_one;
   logic [WORD_WIDTH+1:0] sub_two;

   // The operands are below m, so 2*acc + a stays below 3*m and at most
   // two subtractions of m bring it back into range.
   always_comb begin
      sum     = {1'b0, acc_ff, 1'b0} + {2'b00, (b_ff[WORD_WIDTH-1] ? a_ff : '0)};
      m_one   = {2'b00, m_ff};
      m_two   = {1'b0, m_ff, 1'b0};
      sub_one = sum - m_one;
      sub_two = sum - m_two;
      if (sum >= m_two) begin
         acc_in = sub_two[WORD_WIDTH-1:0];
      end else if (sum >= m_one) begin
         acc_in = sub_one[WORD_WIDTH-1:0];
      end else begin
         acc_in = sum[WORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff   <= operand_a;
         b_ff   <= operand_b;
         m_ff   <= modulus;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff   <= {b_ff[WORD_WIDTH-2:0], 1'b0};
      end
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ===== src/modular_exponentiation.sv =====
// All work runs through the bit-serial modular multiplier, which is used once to reduce
// the input and once per square and per multiply.
// One item is in work at a time; the next is accepted as soon as the result is registered.
// Synchronous active-high reset clears control state; exponent resets to 1, modulus to 2.
`default_nettype none

module modular_exponentiation
   import mexp_pkg::*;
#(
   parameter int unsigned WORD_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [WORD_WIDTH-1:0]      req_message_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [WORD_WIDTH-1:0]           rsp_result_value,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [WORD_WIDTH-1:0]      csr_write_data
);

   localparam int unsigned BIT_CNT_WIDTH = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
   localparam logic [BIT_CNT_WIDTH-1:0] BIT_LAST = BIT_CNT_WIDTH'(WORD_WIDTH - 1);
   localparam logic [WORD_WIDTH-1:0] WORD_ONE = WORD_WIDTH'(1);

   mexp_state_type state_ff, state_in;

   logic [WORD_WIDTH-1:0]    exponent_ff;
   logic [WORD_WIDTH-1:0]    modulus_ff;
   logic [WORD_WIDTH-1:0]    msg_ff;
   logic [WORD_WIDTH-1:0]    base_ff;
   logic [WORD_WIDTH-1:0]    acc_ff;
   logic [WORD_WIDTH-1:0]    exp_ff;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff;
   logic                     launch_ff, launch_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]    rsp_value_ff;

   logic                     req_take;
   logic                     base_load;
   logic                     acc_load;
   logic                     exp_advance;
   logic                     rsp_load;
   logic                     last_bit;
   logic                     out_free;

   logic [WORD_WIDTH-1:0]    mul_a;
   logic [WORD_WIDTH-1:0]    mul_b;
   logic                     mul_busy;
   logic                     mul_done;
   logic [WORD_WIDTH-1:0]    mul_product;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= WORD_ONE;
         modulus_ff  <= WORD_WIDTH'(2);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPONENT: exponent_ff <= csr_write_data;
            CSR_MODULUS:  modulus_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign last_bit  = (bit_cnt_ff == BIT_LAST);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (mul_done) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (mul_done) begin
               if (exp_ff[WORD_WIDTH-1]) begin
                  state_in = ST_MULT;
               end else if (last_bit) begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_MULT: begin
            if (mul_done) state_in = last_bit ? ST_HOLD : ST_SQUARE;
         end
         ST_HOLD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      base_load   = 1'b0;
      acc_load    = 1'b0;
      exp_advance = 1'b0;
      launch_in   = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            launch_in = req_take;
         end
         ST_REDUCE: begin
            base_load = mul_done;
            launch_in = mul_done;
         end
         ST_SQUARE: begin
            acc_load    = mul_done;
            exp_advance = mul_done && !exp_ff[WORD_WIDTH-1];
            launch_in   = mul_done && (exp_ff[WORD_WIDTH-1] || !last_bit);
         end
         ST_MULT: begin
            acc_load    = mul_done;
            exp_advance = mul_done;
            launch_in   = mul_done && !last_bit;
         end
         ST_HOLD: begin
            rsp_load = out_free;
         end
         default: ;
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_REDUCE: begin
            mul_a = WORD_ONE;
            mul_b = msg_ff;
         end
         ST_MULT: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = acc_ff;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            bit_cnt_ff <= '0;
         end else if (exp_advance) begin
            bit_cnt_ff <= bit_cnt_ff + 1'b1;
         end
      end
   end

   // Reducing 1 * msg through the multiplier leaves msg mod m in the base register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         msg_ff <= req_message_value;
         exp_ff <= exponent_ff;
      end else if (exp_advance) begin
         exp_ff <= {exp_ff[WORD_WIDTH-2:0], 1'b0};
      end
      if (base_load) begin
         base_ff <= mul_product;
         acc_ff  <= (modulus_ff == WORD_ONE) ? '0 : WORD_ONE;
      end else if (acc_load) begin
         acc_ff <= mul_product;
      end
      if (rsp_load) begin
         rsp_value_ff <= (modulus_ff == '0) ? '0 : acc_ff;
      end
   end

   mexp_modmul #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_modmul (
      .clock     (clock),
      .reset     (reset),
      .start     (launch_ff),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .modulus   (modulus_ff),
      .busy      (mul_busy),
      .done      (mul_done),
      .product   (mul_product)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   // A new multiplication is never launched while one is still running.
   a_no_launch_busy: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> !mul_busy)
      else $error("multiplier launched while busy");

   // Multiplier completions arrive only in the computing states.
   a_done_in_compute: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_REDUCE || state_ff == ST_SQUARE || state_ff == ST_MULT))
      else $error("multiplier completion outside computation");

   // A result appears only after the sequencer has finished an item.
   a_result_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_HOLD)
      else $error("result registered without a finished item");

   // Every result lies below a nonzero modulus.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (modulus_ff == '0 || rsp_value_ff < modulus_ff))
      else $error("result not reduced below modulus");

endmodule

`default_nettype wire
